@@ rtl/fcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcc_pkg: shared types, constants and helpers for the frame classifier
// Holds protocol codes, frame offsets, result codes, the ones' complement
// add and the structs passed between the classifier modules.
// ----------------------------------------------------------------------------
package fcc_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned MAX_FRAME_BYTES = 65536;
	localparam int unsigned COUNTER_WIDTH   = 32;

	localparam int unsigned NUM_COUNTERS = 8;
	localparam int unsigned CNT_SEL_W    = 3;
	localparam int unsigned VALUE_W      = 32;

	// Frame end offset can reach 14 + 60 + 65535, which needs 17 bits
	localparam int unsigned END_W = 17;

	localparam logic [15:0] TYPE_LIMIT = 16'd1534;
	localparam logic [15:0] TYPE_IPV4  = 16'h0800;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [3:0] MIN_IHL = 4'd5;

	// Byte offsets within the frame
	localparam int unsigned OFF_TYPE_HI   = 12;
	localparam int unsigned OFF_TYPE_LO   = 13;
	localparam int unsigned ETH_HDR       = 14;
	localparam int unsigned OFF_TLEN_HI   = 16;
	localparam int unsigned OFF_TLEN_LO   = 17;
	localparam int unsigned OFF_L4_LEN    = 18;
	localparam int unsigned OFF_L4_END    = 19;
	localparam int unsigned OFF_PROTO     = 23;
	localparam int unsigned OFF_FOLD_PROTO = 24;
	localparam int unsigned OFF_IP_CSUM_LO = 25;
	localparam int unsigned OFF_FOLD_LEN  = 25;
	localparam int unsigned ADDR_FIRST    = 26;
	localparam int unsigned ADDR_LAST     = 33;

	// Checksum field position relative to the layer-4 start
	localparam int unsigned TCP_CSUM_REL = 16;
	localparam int unsigned UDP_CSUM_REL = 6;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic {
		RK_SUMMARY = 1'b0,
		RK_COUNTER = 1'b1
	} result_kind_t;

	typedef enum logic [1:0] {
		L4C_OTHER = 2'd0,
		L4C_ICMP  = 2'd1,
		L4C_TCP   = 2'd2,
		L4C_UDP   = 2'd3
	} l4_class_t;

	typedef enum logic [1:0] {
		L4S_NONE  = 2'd0,
		L4S_OK    = 2'd1,
		L4S_BAD   = 2'd2,
		L4S_SHORT = 2'd3
	} l4_status_t;

	localparam logic [CNT_SEL_W-1:0] CTR_TOTAL  = 3'd0;
	localparam logic [CNT_SEL_W-1:0] CTR_ETH2   = 3'd1;
	localparam logic [CNT_SEL_W-1:0] CTR_8023   = 3'd2;
	localparam logic [CNT_SEL_W-1:0] CTR_IP     = 3'd3;
	localparam logic [CNT_SEL_W-1:0] CTR_NON_IP = 3'd4;
	localparam logic [CNT_SEL_W-1:0] CTR_ICMP   = 3'd5;
	localparam logic [CNT_SEL_W-1:0] CTR_TCP    = 3'd6;
	localparam logic [CNT_SEL_W-1:0] CTR_UDP    = 3'd7;

	typedef struct packed {
		logic        is_ethernet_ii;
		logic        is_ipv4;
		logic [15:0] ether_type;
		l4_class_t   l4_class;
		logic        ip_csum_ok;
		logic [15:0] ip_csum_expected;
		l4_status_t  l4_status;
		logic [15:0] l4_csum_expected;
	} frame_sum_t;

	typedef struct packed {
		logic      bump;
		logic      eth2;
		logic      ip4;
		l4_class_t cls;
	} stat_upd_t;

	// 16-bit ones' complement add with end-around carry
	function automatic logic [15:0] csum_add(input logic [15:0] s, input logic [15:0] w);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, w};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage
`default_nettype wire

@@ rtl/fcc_frame_acc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcc_frame_acc: per-byte frame parser and checksum accumulators
// Captures header fields by offset, keeps the IPv4 and layer-4 ones'
// complement sums, and forms the frame summary on the last byte.
// ----------------------------------------------------------------------------
module fcc_frame_acc #(
	parameter int unsigned MAX_FRAME_BYTES = fcc_pkg::MAX_FRAME_BYTES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_en,
	input  wire logic [7:0]         frame_byte,
	input  wire logic               frame_last,
	output fcc_pkg::stat_upd_t      upd,
	output fcc_pkg::frame_sum_t     summary
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int unsigned CMP_W = (CNT_W > fcc_pkg::END_W) ? CNT_W : fcc_pkg::END_W;
	localparam int unsigned END_W = fcc_pkg::END_W;

	logic [CNT_W-1:0] cnt_q,   cnt_d;
	logic [15:0]      type_q,  type_d;
	logic [3:0]       hw_q,    hw_d;
	logic [15:0]      tlen_q,  tlen_d;
	logic [7:0]       proto_q, proto_d;
	logic [7:0]       hold_q,  hold_d;
	logic [15:0]      ip_full_q, ip_full_d;
	logic [15:0]      ip_wo_q,   ip_wo_d;
	logic [15:0]      l4_full_q, l4_full_d;
	logic [15:0]      l4_wo_q,   l4_wo_d;
	logic [15:0]      len_q,   len_d;
	logic [END_W-1:0] end_q,   end_d;

	logic [CMP_W-1:0] off;
	logic             live;
	logic             odd;
	logic [5:0]       hlen;
	logic [6:0]       start;
	logic [7:0]       fld_off;
	logic [7:0]       fld_off_p1;
	logic [END_W-1:0] end_m1;
	logic [15:0]      word;
	logic             ip_in;
	logic             l4_on;
	logic             l4_add;
	logic             l4_wo_add;
	logic [15:0]      l4_w;
	logic             short_frame;

	assign off        = CMP_W'(cnt_q);
	assign live       = (cnt_q != CNT_W'(MAX_FRAME_BYTES));
	assign odd        = cnt_q[0];
	assign hlen       = {hw_q, 2'b00};
	assign start      = 7'(fcc_pkg::ETH_HDR) + {1'b0, hlen};
	assign fld_off    = {1'b0, start} + ((proto_q == fcc_pkg::PROTO_TCP) ?
		8'(fcc_pkg::TCP_CSUM_REL) : 8'(fcc_pkg::UDP_CSUM_REL));
	assign fld_off_p1 = fld_off + 8'd1;
	assign end_m1     = end_q - END_W'(1);
	assign word       = {hold_q, frame_byte};

	assign ip_in = odd && (off >= CMP_W'(fcc_pkg::ETH_HDR)) && (off < CMP_W'(start));
	assign l4_on = (hw_q >= fcc_pkg::MIN_IHL) && (off >= CMP_W'(start)) &&
		(off < CMP_W'(end_q));

	// Layer-4 sum source: pseudo-header folds, addresses, then payload words
	always_comb begin
		l4_add    = 1'b0;
		l4_wo_add = 1'b0;
		l4_w      = '0;
		if (off == CMP_W'(fcc_pkg::OFF_FOLD_PROTO)) begin
			l4_add    = 1'b1;
			l4_wo_add = 1'b1;
			l4_w      = {8'd0, proto_q};
		end else if (off == CMP_W'(fcc_pkg::OFF_FOLD_LEN)) begin
			l4_add    = 1'b1;
			l4_wo_add = 1'b1;
			l4_w      = len_q;
		end else if (odd && (off >= CMP_W'(fcc_pkg::ADDR_FIRST)) &&
			(off <= CMP_W'(fcc_pkg::ADDR_LAST))) begin
			l4_add    = 1'b1;
			l4_wo_add = 1'b1;
			l4_w      = word;
		end else if (l4_on && odd) begin
			l4_add    = 1'b1;
			l4_wo_add = (off != CMP_W'(fld_off_p1));
			l4_w      = word;
		end else if (l4_on && (off == CMP_W'(end_m1))) begin
			l4_add    = 1'b1;
			l4_wo_add = (off != CMP_W'(fld_off));
			l4_w      = {frame_byte, 8'h00};
		end
	end

	always_comb begin
		cnt_d     = cnt_q;
		type_d    = type_q;
		hw_d      = hw_q;
		tlen_d    = tlen_q;
		proto_d   = proto_q;
		hold_d    = hold_q;
		ip_full_d = ip_full_q;
		ip_wo_d   = ip_wo_q;
		l4_full_d = l4_full_q;
		l4_wo_d   = l4_wo_q;
		len_d     = len_q;
		end_d     = end_q;
		if (live) begin
			cnt_d = cnt_q + CNT_W'(1);
			if (off == CMP_W'(fcc_pkg::OFF_TYPE_HI)) type_d[15:8] = frame_byte;
			if (off == CMP_W'(fcc_pkg::OFF_TYPE_LO)) type_d[7:0]  = frame_byte;
			if (off == CMP_W'(fcc_pkg::ETH_HDR))     hw_d         = frame_byte[3:0];
			if (off == CMP_W'(fcc_pkg::OFF_TLEN_HI)) tlen_d[15:8] = frame_byte;
			if (off == CMP_W'(fcc_pkg::OFF_TLEN_LO)) tlen_d[7:0]  = frame_byte;
			if (off == CMP_W'(fcc_pkg::OFF_PROTO))   proto_d      = frame_byte;
			if (off == CMP_W'(fcc_pkg::OFF_L4_LEN))  len_d = tlen_q - {10'd0, hlen};
			if (off == CMP_W'(fcc_pkg::OFF_L4_END))
				end_d = END_W'(start) + END_W'(len_q);
			if (!odd) hold_d = frame_byte;
			if (ip_in) begin
				ip_full_d = fcc_pkg::csum_add(ip_full_q, word);
				if (off != CMP_W'(fcc_pkg::OFF_IP_CSUM_LO))
					ip_wo_d = fcc_pkg::csum_add(ip_wo_q, word);
			end
			if (l4_add)    l4_full_d = fcc_pkg::csum_add(l4_full_q, l4_w);
			if (l4_wo_add) l4_wo_d   = fcc_pkg::csum_add(l4_wo_q, l4_w);
		end
	end

	// Summary from the state as it stands after this byte
	always_comb begin
		summary                = '0;
		summary.ether_type     = type_d;
		summary.is_ethernet_ii = (type_d > fcc_pkg::TYPE_LIMIT);
		summary.is_ipv4        = (type_d == fcc_pkg::TYPE_IPV4);
		short_frame            = (CMP_W'(cnt_d) < CMP_W'(end_d));
		if (summary.is_ipv4) begin
			priority if (proto_d == fcc_pkg::PROTO_ICMP) summary.l4_class = fcc_pkg::L4C_ICMP;
			else if (proto_d == fcc_pkg::PROTO_TCP)      summary.l4_class = fcc_pkg::L4C_TCP;
			else if (proto_d == fcc_pkg::PROTO_UDP)      summary.l4_class = fcc_pkg::L4C_UDP;
			else                                         summary.l4_class = fcc_pkg::L4C_OTHER;
			summary.ip_csum_ok       = (ip_full_d == 16'hFFFF);
			summary.ip_csum_expected = ~ip_wo_d;
			if ((summary.l4_class == fcc_pkg::L4C_TCP || summary.l4_class == fcc_pkg::L4C_UDP) &&
				(hw_d >= fcc_pkg::MIN_IHL)) begin
				if (short_frame) begin
					summary.l4_status = fcc_pkg::L4S_SHORT;
				end else begin
					summary.l4_status = (l4_full_d == 16'hFFFF) ? fcc_pkg::L4S_OK :
						fcc_pkg::L4S_BAD;
					summary.l4_csum_expected = ~l4_wo_d;
				end
			end
		end
	end

	assign upd.bump = byte_en && frame_last;
	assign upd.eth2 = summary.is_ethernet_ii;
	assign upd.ip4  = summary.is_ipv4;
	assign upd.cls  = summary.l4_class;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			type_q    <= '0;
			hw_q      <= '0;
			tlen_q    <= '0;
			proto_q   <= '0;
			hold_q    <= '0;
			ip_full_q <= '0;
			ip_wo_q   <= '0;
			l4_full_q <= '0;
			l4_wo_q   <= '0;
			len_q     <= '0;
			end_q     <= '1;
		end else if (byte_en) begin
			if (frame_last) begin
				cnt_q     <= '0;
				type_q    <= '0;
				hw_q      <= '0;
				tlen_q    <= '0;
				proto_q   <= '0;
				hold_q    <= '0;
				ip_full_q <= '0;
				ip_wo_q   <= '0;
				l4_full_q <= '0;
				l4_wo_q   <= '0;
				len_q     <= '0;
				end_q     <= '1;
			end else begin
				cnt_q     <= cnt_d;
				type_q    <= type_d;
				hw_q      <= hw_d;
				tlen_q    <= tlen_d;
				proto_q   <= proto_d;
				hold_q    <= hold_d;
				ip_full_q <= ip_full_d;
				ip_wo_q   <= ip_wo_d;
				l4_full_q <= l4_full_d;
				l4_wo_q   <= l4_wo_d;
				len_q     <= len_d;
				end_q     <= end_d;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/fcc_stats.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcc_stats: per-frame statistic counters
// Eight wrapping counters bumped once per finished frame, read by index.
// ----------------------------------------------------------------------------
module fcc_stats #(
	parameter int unsigned COUNTER_WIDTH = fcc_pkg::COUNTER_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  fcc_pkg::stat_upd_t                   upd,
	input  wire logic [fcc_pkg::CNT_SEL_W-1:0]   rd_sel,
	output logic [fcc_pkg::VALUE_W-1:0]          rd_value
);

	logic [COUNTER_WIDTH-1:0]       ctr_q [fcc_pkg::NUM_COUNTERS];
	logic [fcc_pkg::NUM_COUNTERS-1:0] hit;

	always_comb begin
		hit = '0;
		hit[fcc_pkg::CTR_TOTAL] = 1'b1;
		hit[upd.eth2 ? fcc_pkg::CTR_ETH2 : fcc_pkg::CTR_8023] = 1'b1;
		if (upd.ip4) begin
			hit[fcc_pkg::CTR_IP] = 1'b1;
			unique case (upd.cls)
				fcc_pkg::L4C_ICMP:  hit[fcc_pkg::CTR_ICMP] = 1'b1;
				fcc_pkg::L4C_TCP:   hit[fcc_pkg::CTR_TCP]  = 1'b1;
				fcc_pkg::L4C_UDP:   hit[fcc_pkg::CTR_UDP]  = 1'b1;
				fcc_pkg::L4C_OTHER: ;
				default: ;
			endcase
		end else begin
			hit[fcc_pkg::CTR_NON_IP] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fcc_pkg::NUM_COUNTERS; i++) ctr_q[i] <= '0;
		end else if (upd.bump) begin
			for (int i = 0; i < fcc_pkg::NUM_COUNTERS; i++) begin
				if (hit[i]) ctr_q[i] <= ctr_q[i] + COUNTER_WIDTH'(1);
			end
		end
	end

	assign rd_value = fcc_pkg::VALUE_W'(ctr_q[rd_sel]);

endmodule
`default_nettype wire

@@ rtl/frame_classifier_checksum_check_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted request is registered in the input stage, its result loaded
//   into the output register. Throughput: one request per cycle, set by the
// single-byte accumulator update, unless a result is held back by out_stall.
// Reset (arst_n low): frame state, statistic counters and all valid flags clear.
// ----------------------------------------------------------------------------
// frame_classifier_checksum_check_unit: Ethernet/IPv4 frame classifier
// Takes frame bytes or counter reads, checks IPv4 header and TCP/UDP
// checksums, and returns one summary per frame or one counter value per read.
// ----------------------------------------------------------------------------
module frame_classifier_checksum_check_unit #(
	parameter int unsigned MAX_FRAME_BYTES = fcc_pkg::MAX_FRAME_BYTES,
	parameter int unsigned COUNTER_WIDTH   = fcc_pkg::COUNTER_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        frame_last,
	input  wire logic [2:0]  counter_select,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             result_kind,
	output logic             is_ethernet_ii,
	output logic             is_ipv4,
	output logic [15:0]      ether_type,
	output logic [1:0]       l4_class,
	output logic             ip_csum_ok,
	output logic [15:0]      ip_csum_expected,
	output logic [1:0]       l4_status,
	output logic [15:0]      l4_csum_expected,
	output logic [31:0]      counter_value
);

	// Input register stage
	logic                              s1_valid;
	fcc_pkg::op_t                      s1_op;
	logic [7:0]                        s1_byte;
	logic                              s1_last;
	logic [fcc_pkg::CNT_SEL_W-1:0]     s1_sel;

	logic s1_has_result;
	logic s1_go;
	logic out_free;
	logic byte_en;
	logic in_take;

	fcc_pkg::frame_sum_t  summary;
	fcc_pkg::stat_upd_t   upd;
	logic [fcc_pkg::VALUE_W-1:0] rd_value;

	// Result register
	logic                  out_valid_q;
	fcc_pkg::result_kind_t kind_q;
	fcc_pkg::frame_sum_t   sum_q;
	logic [31:0]           value_q;

	// A read always answers; a frame byte answers only when it closes the frame.
	// Bytes with no result move on even while the result register is full.
	assign s1_has_result = (s1_op == fcc_pkg::OP_READ) || s1_last;
	assign out_free      = !out_valid_q || !out_stall;
	assign s1_go         = s1_valid && (!s1_has_result || out_free);
	assign in_stall      = s1_valid && !s1_go;
	assign in_take       = in_valid && !in_stall;
	assign byte_en       = s1_go && (s1_op == fcc_pkg::OP_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_take) begin
			s1_valid <= 1'b1;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	// Payload of the input stage: hold while stalled, load on accept
	always_ff @(posedge clk) begin
		if (in_take) begin
			s1_op   <= fcc_pkg::op_t'(op);
			s1_byte <= frame_byte;
			s1_last <= frame_last;
			s1_sel  <= counter_select;
		end
	end

	fcc_frame_acc #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_frame_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (byte_en),
		.frame_byte (s1_byte),
		.frame_last (s1_last),
		.upd        (upd),
		.summary    (summary)
	);

	// Counter reads see every frame finished by earlier requests
	fcc_stats #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.rd_sel   (s1_sel),
		.rd_value (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result register; hold it while the consumer stalls
	always_ff @(posedge clk) begin
		if (s1_go && s1_has_result) begin
			if (s1_op == fcc_pkg::OP_READ) begin
				kind_q  <= fcc_pkg::RK_COUNTER;
				sum_q   <= '0;
				value_q <= rd_value;
			end else begin
				kind_q  <= fcc_pkg::RK_SUMMARY;
				sum_q   <= summary;
				value_q <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = kind_q;
	assign is_ethernet_ii   = sum_q.is_ethernet_ii;
	assign is_ipv4          = sum_q.is_ipv4;
	assign ether_type       = sum_q.ether_type;
	assign l4_class         = sum_q.l4_class;
	assign ip_csum_ok       = sum_q.ip_csum_ok;
	assign ip_csum_expected = sum_q.ip_csum_expected;
	assign l4_status        = sum_q.l4_status;
	assign l4_csum_expected = sum_q.l4_csum_expected;
	assign counter_value    = value_q;

endmodule
`default_nettype wire
